/* src/stq_pkg.sv */
// Package with the shared types and constants of the software timer queue.
package stq_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int EXP_W       = $clog2(MAX_RESULTS + 2);

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] EV_FIRED    = 2'd0;
   localparam logic [1:0] EV_ACK      = 2'd1;
   localparam logic [1:0] EV_FULL     = 2'd2;
   localparam logic [1:0] EV_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] timer_id;
      logic [31:0] delay_ms;
      logic        repeat_flag;
      logic [47:0] time_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] fired_id;
      logic        last_result;
      logic        queue_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      SCAN_FREE,
      SCAN_DEL,
      SCAN_MIN
   } scan_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_CLEAR,
      CMD_FIRE
   } cmd_type;

   // Control part of the token that walks down the row of slot cells.
   typedef struct packed {
      logic              active;
      scan_type          op;
      logic              found;
      logic              rep;
      logic              blocker;
      logic [EXP_W-1:0]  exp_cnt;
   } carry_type;

endpackage

/* src/stq_cell.sv */
// One timer slot of the row, with its share of the scan token pipeline.
module stq_cell #(
   parameter int TB         = 48,
   parameter int IW         = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stq_pkg::cmd_type     cmd,
   input  logic [IW-1:0]        cmd_idx,
   input  logic [31:0]          item_id,
   input  logic [TB-1:0]        item_target,
   input  logic [31:0]          item_period,
   input  logic                 item_rep,
   input  logic [TB-1:0]        now,
   input  stq_pkg::carry_type   c_in,
   input  logic [TB-1:0]        c_target_in,
   input  logic [IW-1:0]        c_idx_in,
   input  logic [31:0]          c_id_in,
   output stq_pkg::carry_type   c_out,
   output logic [TB-1:0]        c_target_out,
   output logic [IW-1:0]        c_idx_out,
   output logic [31:0]          c_id_out
);

   logic                valid_ff;
   logic [31:0]         id_ff;
   logic [TB-1:0]       target_ff;
   logic [31:0]         period_ff;
   logic                rep_ff;

   stq_pkg::carry_type  c_ff, c_in_next;
   logic [TB-1:0]       c_target_ff, c_target_in_next;
   logic [IW-1:0]       c_idx_ff, c_idx_in_next;
   logic [31:0]         c_id_ff, c_id_in_next;

   logic                hit, expired, take;
   logic [TB:0]         rearm_sum;
   logic [TB-1:0]       rearm_target;

   assign hit       = (cmd_idx == IW'(CELL_INDEX));
   assign expired   = valid_ff && (target_ff < now);
   assign rearm_sum = (TB+1)'(now) + (TB+1)'(period_ff);
   assign rearm_target = rearm_sum[TB] ? {TB{1'b1}} : rearm_sum[TB-1:0];

   always_comb begin
      case (c_in.op)
         stq_pkg::SCAN_FREE: take = !c_in.found && !valid_ff;
         stq_pkg::SCAN_DEL:  take = !c_in.found && valid_ff && (id_ff == item_id);
         stq_pkg::SCAN_MIN:  take = expired && (!c_in.found || target_ff < c_target_in);
         default:            take = 1'b0;
      endcase
   end

   always_comb begin
      c_in_next        = c_in;
      c_target_in_next = c_target_in;
      c_idx_in_next    = c_idx_in;
      c_id_in_next     = c_id_in;
      if (c_in.active) begin
         if (valid_ff && (!expired || rep_ff)) begin
            c_in_next.blocker = 1'b1;
         end
         if (expired && c_in.exp_cnt != stq_pkg::EXP_W'(stq_pkg::MAX_RESULTS + 1)) begin
            c_in_next.exp_cnt = c_in.exp_cnt + 1'b1;
         end
         if (take) begin
            c_in_next.found  = 1'b1;
            c_in_next.rep    = rep_ff;
            c_target_in_next = target_ff;
            c_idx_in_next    = IW'(CELL_INDEX);
            c_id_in_next     = id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         c_ff     <= '0;
      end else begin
         c_ff <= c_in_next;
         if (hit) begin
            case (cmd)
               stq_pkg::CMD_WRITE: valid_ff <= 1'b1;
               stq_pkg::CMD_CLEAR: valid_ff <= 1'b0;
               stq_pkg::CMD_FIRE:  valid_ff <= rep_ff;
               default:            valid_ff <= valid_ff;
            endcase
         end
      end
      c_target_ff <= c_target_in_next;
      c_idx_ff    <= c_idx_in_next;
      c_id_ff     <= c_id_in_next;
      if (hit && cmd == stq_pkg::CMD_WRITE) begin
         id_ff     <= item_id;
         target_ff <= item_target;
         period_ff <= item_period;
         rep_ff    <= item_rep;
      end else if (hit && cmd == stq_pkg::CMD_FIRE && rep_ff) begin
         target_ff <= rearm_target;
      end
   end

   assign c_out        = c_ff;
   assign c_target_out = c_target_ff;
   assign c_idx_out    = c_idx_ff;
   assign c_id_out     = c_id_ff;

endmodule

/* src/software_timer_queue_unit.sv */
// Top level of the software timer queue: controller and the row of slot cells.
//
// The block holds TIMER_SLOTS timers in a row of identical cells. Every request
// (create, delete, tick) that needs the table sends one scan token from the
// first cell to the last, one cell per clock, until the controller captures it
// behind the last cell; the token finds the lowest free slot, the lowest slot
// holding an id, or the earliest expired timer. A create or a delete costs one
// scan. A tick costs one scan for each timer it fires (at most sixteen, counted
// on the first scan), or one scan when nothing fires. A zero-delay one-shot
// create and an unused action code are answered without a scan. One request is
// handled at a time; the next transfer is taken as soon as the last result of
// the previous one sits in the output register, even while that result still
// waits to be taken. Each result carries queue_empty as it will stand after the
// whole request, and last_result marks the final result.
module software_timer_queue_unit #(
   parameter int TIMER_SLOTS = 16,
   parameter int TIME_BITS   = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stq_pkg::rsp_type  rsp_data
);

   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int TB = TIME_BITS;
   localparam int EW = stq_pkg::EXP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_LAUNCH
   } state_type;

   state_type           state_ff;

   // Fields of the request in progress.
   logic [31:0]         id_ff;
   logic [31:0]         delay_ff;
   logic                rep_ff;
   logic [TB-1:0]       now_ff;
   logic [TB-1:0]       wtarget_ff;
   stq_pkg::scan_type   op_ff;

   logic [CW-1:0]       count_ff;
   logic                first_ff;
   logic                pred_empty_ff;
   logic [EW-1:0]       total_ff;
   logic [EW-1:0]       fires_ff;

   // Result and table update waiting for the output register.
   stq_pkg::rsp_type    pend_ff;
   stq_pkg::cmd_type    pend_cmd_ff;
   logic [IW-1:0]       pend_idx_ff;
   logic                pend_rep_ff;
   logic                pend_more_ff;

   stq_pkg::cmd_type    cmd_ff;
   logic [IW-1:0]       cmd_idx_ff;
   stq_pkg::carry_type  launch_ff;

   logic                rsp_valid_ff;
   stq_pkg::rsp_type    rsp_data_ff;

   // Token pipeline through the cells; entry 0 is the launch register.
   stq_pkg::carry_type  chain [TIMER_SLOTS+1];
   logic [TB-1:0]       chain_target [TIMER_SLOTS+1];
   logic [IW-1:0]       chain_idx [TIMER_SLOTS+1];
   logic [31:0]         chain_id [TIMER_SLOTS+1];

   stq_pkg::carry_type  tail;
   logic [TB:0]         req_sum;
   logic [TB-1:0]       req_now, req_target;
   logic                accept, rsp_free;
   logic [EW-1:0]       tick_total;
   logic                tick_empty;

   assign chain[0]        = launch_ff;
   assign chain_target[0] = '0;
   assign chain_idx[0]    = '0;
   assign chain_id[0]     = '0;

   genvar gi;
   generate
      for (gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
         stq_cell #(
            .TB         (TB),
            .IW         (IW),
            .CELL_INDEX (gi)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd_ff),
            .cmd_idx      (cmd_idx_ff),
            .item_id      (id_ff),
            .item_target  (wtarget_ff),
            .item_period  (delay_ff),
            .item_rep     (rep_ff),
            .now          (now_ff),
            .c_in         (chain[gi]),
            .c_target_in  (chain_target[gi]),
            .c_idx_in     (chain_idx[gi]),
            .c_id_in      (chain_id[gi]),
            .c_out        (chain[gi+1]),
            .c_target_out (chain_target[gi+1]),
            .c_idx_out    (chain_idx[gi+1]),
            .c_id_out     (chain_id[gi+1])
         );
      end
   endgenerate

   assign tail     = chain[TIMER_SLOTS];
   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Target of a stored timer saturates at the top of the time range.
   assign req_now    = TB'(req_data.time_value);
   assign req_sum    = (TB+1)'(req_now) + (TB+1)'(req_data.delay_ms);
   assign req_target = req_sum[TB] ? {TB{1'b1}} : req_sum[TB-1:0];

   // On the first scan of a tick the token has counted the expired timers and
   // seen whether any timer will survive the tick.
   always_comb begin
      if (first_ff) begin
         tick_total = (tail.exp_cnt > EW'(stq_pkg::MAX_RESULTS)) ?
                      EW'(stq_pkg::MAX_RESULTS) : tail.exp_cnt;
         tick_empty = !tail.blocker && (tail.exp_cnt <= EW'(stq_pkg::MAX_RESULTS));
      end else begin
         tick_total = total_ff;
         tick_empty = pred_empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmd_ff       <= stq_pkg::CMD_NONE;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         cmd_ff           <= stq_pkg::CMD_NONE;
         launch_ff.active <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  id_ff        <= req_data.timer_id;
                  delay_ff     <= req_data.delay_ms;
                  rep_ff       <= req_data.repeat_flag;
                  now_ff       <= req_now;
                  wtarget_ff   <= req_target;
                  first_ff     <= 1'b1;
                  fires_ff     <= '0;
                  pend_cmd_ff  <= stq_pkg::CMD_NONE;
                  pend_more_ff <= 1'b0;
                  pend_ff.fired_id    <= '0;
                  pend_ff.last_result <= 1'b1;
                  pend_ff.queue_empty <= (count_ff == '0);
                  launch_ff <= '0;
                  if (req_data.action == stq_pkg::ACT_CREATE &&
                      req_data.delay_ms == '0 && !req_data.repeat_flag) begin
                     pend_ff.event_kind <= stq_pkg::EV_FIRED;
                     pend_ff.fired_id   <= req_data.timer_id;
                     state_ff           <= ST_EMIT;
                  end else if (req_data.action == stq_pkg::ACT_CREATE) begin
                     launch_ff.active <= 1'b1;
                     launch_ff.op     <= stq_pkg::SCAN_FREE;
                     op_ff            <= stq_pkg::SCAN_FREE;
                     state_ff         <= ST_SCAN;
                  end else if (req_data.action == stq_pkg::ACT_DELETE) begin
                     launch_ff.active <= 1'b1;
                     launch_ff.op     <= stq_pkg::SCAN_DEL;
                     op_ff            <= stq_pkg::SCAN_DEL;
                     state_ff         <= ST_SCAN;
                  end else if (req_data.action == stq_pkg::ACT_TICK) begin
                     launch_ff.active <= 1'b1;
                     launch_ff.op     <= stq_pkg::SCAN_MIN;
                     op_ff            <= stq_pkg::SCAN_MIN;
                     state_ff         <= ST_SCAN;
                  end else begin
                     // The unused action code is simply acknowledged.
                     pend_ff.event_kind <= stq_pkg::EV_ACK;
                     state_ff           <= ST_EMIT;
                  end
               end
            end
            ST_SCAN: begin
               if (tail.active) begin
                  pend_idx_ff         <= chain_idx[TIMER_SLOTS];
                  pend_rep_ff         <= tail.rep;
                  pend_ff.fired_id    <= '0;
                  pend_ff.last_result <= 1'b1;
                  pend_more_ff        <= 1'b0;
                  pend_cmd_ff         <= stq_pkg::CMD_NONE;
                  state_ff            <= ST_EMIT;
                  case (op_ff)
                     stq_pkg::SCAN_FREE: begin
                        if (tail.found) begin
                           pend_cmd_ff         <= stq_pkg::CMD_WRITE;
                           pend_ff.event_kind  <= stq_pkg::EV_ACK;
                           pend_ff.queue_empty <= 1'b0;
                        end else begin
                           pend_ff.event_kind  <= stq_pkg::EV_FULL;
                           pend_ff.queue_empty <= (count_ff == '0);
                        end
                     end
                     stq_pkg::SCAN_DEL: begin
                        if (tail.found) begin
                           pend_cmd_ff         <= stq_pkg::CMD_CLEAR;
                           pend_ff.event_kind  <= stq_pkg::EV_ACK;
                           pend_ff.queue_empty <= (count_ff == CW'(1));
                        end else begin
                           pend_ff.event_kind  <= stq_pkg::EV_NOTFOUND;
                           pend_ff.queue_empty <= (count_ff == '0);
                        end
                     end
                     default: begin
                        first_ff            <= 1'b0;
                        total_ff            <= tick_total;
                        pred_empty_ff       <= tick_empty;
                        pend_ff.queue_empty <= tick_empty;
                        if (tail.found) begin
                           pend_cmd_ff         <= stq_pkg::CMD_FIRE;
                           pend_ff.event_kind  <= stq_pkg::EV_FIRED;
                           pend_ff.fired_id    <= chain_id[TIMER_SLOTS];
                           pend_ff.last_result <= (fires_ff + 1'b1 == tick_total);
                           pend_more_ff        <= (fires_ff + 1'b1 != tick_total);
                        end else begin
                           pend_ff.event_kind  <= stq_pkg::EV_ACK;
                        end
                     end
                  endcase
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= pend_ff;
                  cmd_ff       <= pend_cmd_ff;
                  cmd_idx_ff   <= pend_idx_ff;
                  if (pend_cmd_ff == stq_pkg::CMD_WRITE) begin
                     count_ff <= count_ff + 1'b1;
                  end else if (pend_cmd_ff == stq_pkg::CMD_CLEAR ||
                               (pend_cmd_ff == stq_pkg::CMD_FIRE && !pend_rep_ff)) begin
                     count_ff <= count_ff - 1'b1;
                  end
                  if (pend_more_ff) begin
                     // Another expired timer remains: the rescan launches from ST_LAUNCH, so
                     // the fired slot has taken its update before the token reaches it.
                     fires_ff <= fires_ff + 1'b1;
                     state_ff <= ST_LAUNCH;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_LAUNCH: begin
               launch_ff        <= '0;
               launch_ff.active <= 1'b1;
               launch_ff.op     <= stq_pkg::SCAN_MIN;
               state_ff         <= ST_SCAN;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/stq_checker.sv */
// Port-level assertions for the software timer queue and their bind.
module stq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input stq_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input stq_pkg::rsp_type  rsp_data
);

   // A waiting result is held until its transfer completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Requests are handled one at a time, so an accepted request blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in progress");

   // Only a fired event carries an id.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind != stq_pkg::EV_FIRED |-> rsp_data.fired_id == '0)
      else $error("id on a non-fire result");

   // A full table can never be reported as empty.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == stq_pkg::EV_FULL |-> !rsp_data.queue_empty)
      else $error("table full reported with empty queue");

endmodule

bind software_timer_queue_unit stq_checker u_stq_checker (.*);
